### hw/rtl/ogfq_pkg.sv
// ogfq_pkg: shared types and constants for the obstacle gap fit query block.
// No dependencies.
`default_nettype none
package ogfq_pkg;

    localparam int DW = 10;  // width of positions, sizes and gap values

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_PLACE_CHK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_MARK,
        ST_LEAF_B,
        ST_WALK,
        ST_UP,
        ST_NEXT_CHK,
        ST_NEXT_RD,
        ST_NEXT_TEST,
        ST_Q_INIT,
        ST_Q_CHK,
        ST_Q_ACC_LO,
        ST_Q_HI,
        ST_Q_ACC_HI,
        ST_Q_SHIFT,
        ST_OUT_FAIL,
        ST_OUT_BEST
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_MAP_RD,
        OP_DEC,
        OP_INC,
        OP_MARK_PREV,
        OP_MAP_WR,
        OP_LEAF_BEFORE,
        OP_LEAF_AFTER,
        OP_SIB_RD,
        OP_UP,
        OP_SET_NEXT,
        OP_QINIT,
        OP_RD_LO,
        OP_RD_HI,
        OP_ACC,
        OP_SHIFT,
        OP_OUT_FAIL,
        OP_OUT_BEST
    } t_dp_op;

    typedef struct packed {
        logic in_range;   // latched position lies on the line
        logic map_hit;    // registered obstacle map read
        logic node_gt1;   // tree walk not yet at root
        logic lo_lt_hi;
        logic lo_odd;
        logic hi_odd;
        logic x_lt_size;
        logic is_query;
        logic xa_last;    // placed position is the last one
        logic cur_last;   // scan cursor at the last position
        logic clr_last;
        logic out_busy;   // result register still holds an untaken item
    } t_dp_stat;

endpackage
`default_nettype wire

### hw/rtl/ogfq_if.sv
// ogfq_in_if / ogfq_out_if: valid-ready channels for input and result items.
// Depends on ogfq_pkg for the field width.
`default_nettype none
interface ogfq_in_if;
    import ogfq_pkg::*;
    logic          valid;
    logic          ready;
    logic          func;
    logic [DW-1:0] position;
    logic [DW-1:0] block_size;
    modport source (output valid, func, position, block_size, input ready);
    modport sink   (input valid, func, position, block_size, output ready);
endinterface

interface ogfq_out_if;
    logic valid;
    logic ready;
    logic fits;
    modport source (output valid, fits, input ready);
    modport sink   (input valid, fits, output ready);
endinterface
`default_nettype wire

### hw/rtl/ogfq_ctrl.sv
// ogfq_ctrl: sequencer for place and query items; drives datapath commands.
// Depends on ogfq_pkg.
`default_nettype none
module ogfq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire ogfq_pkg::t_dp_stat i_stat,
    output ogfq_pkg::t_dp_op       o_op
);
    import ogfq_pkg::*;

    t_state r_state, n_state;
    logic   r_after, n_after;  // walking up from the following obstacle's leaf

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_after <= 1'b0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_after    = r_after;
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_op = OP_CLEAR;
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_stat.is_query) begin
                    if (i_stat.x_lt_size) begin
                        n_state = ST_OUT_FAIL;
                    end else begin
                        o_op    = OP_MAP_RD;
                        n_state = ST_SCAN_CHK;
                    end
                end else if (!i_stat.in_range) begin
                    n_state = ST_IDLE;
                end else begin
                    o_op    = OP_MAP_RD;
                    n_state = ST_PLACE_CHK;
                end
            end
            ST_PLACE_CHK: begin
                if (i_stat.map_hit) begin
                    n_state = ST_IDLE;
                end else begin
                    o_op    = OP_DEC;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                o_op    = OP_MAP_RD;
                n_state = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (i_stat.map_hit) begin
                    o_op    = OP_MARK_PREV;
                    n_state = i_stat.is_query ? ST_Q_INIT : ST_MARK;
                end else begin
                    o_op    = OP_DEC;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_MARK: begin
                o_op    = OP_MAP_WR;
                n_state = ST_LEAF_B;
            end
            ST_LEAF_B: begin
                o_op    = OP_LEAF_BEFORE;
                n_after = 1'b0;
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (i_stat.node_gt1) begin
                    o_op    = OP_SIB_RD;
                    n_state = ST_UP;
                end else begin
                    n_state = r_after ? ST_IDLE : ST_NEXT_CHK;
                end
            end
            ST_UP: begin
                o_op    = OP_UP;
                n_state = ST_WALK;
            end
            ST_NEXT_CHK: begin
                if (i_stat.xa_last) begin
                    n_state = ST_IDLE;
                end else begin
                    o_op    = OP_SET_NEXT;
                    n_state = ST_NEXT_RD;
                end
            end
            ST_NEXT_RD: begin
                o_op    = OP_MAP_RD;
                n_state = ST_NEXT_TEST;
            end
            ST_NEXT_TEST: begin
                if (i_stat.map_hit) begin
                    o_op    = OP_LEAF_AFTER;
                    n_after = 1'b1;
                    n_state = ST_WALK;
                end else if (i_stat.cur_last) begin
                    n_state = ST_IDLE;
                end else begin
                    o_op    = OP_INC;
                    n_state = ST_NEXT_RD;
                end
            end
            ST_Q_INIT: begin
                o_op    = OP_QINIT;
                n_state = ST_Q_CHK;
            end
            ST_Q_CHK: begin
                if (!i_stat.lo_lt_hi) begin
                    n_state = ST_OUT_BEST;
                end else if (i_stat.lo_odd) begin
                    o_op    = OP_RD_LO;
                    n_state = ST_Q_ACC_LO;
                end else begin
                    n_state = ST_Q_HI;
                end
            end
            ST_Q_ACC_LO: begin
                o_op    = OP_ACC;
                n_state = ST_Q_HI;
            end
            ST_Q_HI: begin
                if (i_stat.hi_odd) begin
                    o_op    = OP_RD_HI;
                    n_state = ST_Q_ACC_HI;
                end else begin
                    o_op    = OP_SHIFT;
                    n_state = ST_Q_CHK;
                end
            end
            ST_Q_ACC_HI: begin
                o_op    = OP_ACC;
                n_state = ST_Q_SHIFT;
            end
            ST_Q_SHIFT: begin
                o_op    = OP_SHIFT;
                n_state = ST_Q_CHK;
            end
            ST_OUT_FAIL: begin
                if (!i_stat.out_busy) begin
                    o_op    = OP_OUT_FAIL;
                    n_state = ST_IDLE;
                end
            end
            ST_OUT_BEST: begin
                if (!i_stat.out_busy) begin
                    o_op    = OP_OUT_BEST;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Nothing is loaded while the stores are still being cleared.
    a_no_load_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (o_op != OP_LOAD))
        else $error("item loaded during clearing pass");

    // A result is only produced from a query.
    a_out_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == OP_OUT_FAIL || o_op == OP_OUT_BEST) |-> i_stat.is_query)
        else $error("result produced for a place item");

    // A result is never written over an untaken one.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == OP_OUT_FAIL || o_op == OP_OUT_BEST) |-> !i_stat.out_busy)
        else $error("result register overwritten");

endmodule
`default_nettype wire

### hw/rtl/ogfq_dp.sv
// ogfq_dp: obstacle map and gap max tree memories, cursors and result register.
// Depends on ogfq_pkg; commanded by ogfq_ctrl.
`default_nettype none
module ogfq_dp #(
    parameter int POSITIONS = 1024
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire ogfq_pkg::t_dp_op       i_op,
    input  wire logic                   i_func,
    input  wire logic [ogfq_pkg::DW-1:0] i_position,
    input  wire logic [ogfq_pkg::DW-1:0] i_block_size,
    input  wire logic                   i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_fits,
    output ogfq_pkg::t_dp_stat          o_stat
);
    import ogfq_pkg::*;

    localparam int AW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
    localparam int TW = $clog2(2 * POSITIONS);
    localparam int HW = $clog2(2 * POSITIONS + 1);

    logic          map_mem  [POSITIONS];
    logic [DW-1:0] tree_mem [2 * POSITIONS];

    logic          r_func;
    logic [DW-1:0] r_x, r_size;
    logic [AW-1:0] r_xa, r_cur, r_prev;
    logic [TW-1:0] r_node, r_clr;
    logic [HW-1:0] r_lo, r_hi;
    logic [DW-1:0] r_val, r_best, r_tree_q;
    logic          r_map_q, r_in_range;
    logic          r_out_valid, r_fits;

    logic [DW-1:0] up_val;
    logic [TW-1:0] t_rd_addr, t_wr_addr;
    logic [DW-1:0] t_wr_data;
    logic          t_wr_en;
    logic [AW-1:0] leaf_b_pos;

    assign up_val     = (r_val > r_tree_q) ? r_val : r_tree_q;
    assign leaf_b_pos = r_xa;

    always_comb begin
        t_rd_addr = r_node ^ TW'(1);
        case (i_op)
            OP_RD_LO: t_rd_addr = r_lo[TW-1:0];
            OP_RD_HI: t_rd_addr = TW'(r_hi - HW'(1));
            default:  t_rd_addr = r_node ^ TW'(1);
        endcase
    end

    always_comb begin
        t_wr_en   = 1'b0;
        t_wr_addr = r_clr;
        t_wr_data = '0;
        case (i_op)
            OP_CLEAR: t_wr_en = 1'b1;
            OP_LEAF_BEFORE: begin
                t_wr_en   = 1'b1;
                t_wr_addr = TW'(POSITIONS) + TW'(leaf_b_pos);
                t_wr_data = DW'(r_xa - r_prev);
            end
            OP_LEAF_AFTER: begin
                t_wr_en   = 1'b1;
                t_wr_addr = TW'(POSITIONS) + TW'(r_cur);
                t_wr_data = DW'(r_cur - r_xa);
            end
            OP_UP: begin
                t_wr_en   = 1'b1;
                t_wr_addr = r_node >> 1;
                t_wr_data = up_val;
            end
            default: t_wr_en = 1'b0;
        endcase
    end

    // Tree memory: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (t_wr_en) tree_mem[t_wr_addr] <= t_wr_data;
        r_tree_q <= tree_mem[t_rd_addr];
    end

    // Obstacle map: position zero always reads as an obstacle.
    always_ff @(posedge i_clk) begin
        if (i_op == OP_CLEAR && 32'(r_clr) < POSITIONS) map_mem[r_clr[AW-1:0]] <= 1'b0;
        else if (i_op == OP_MAP_WR) map_mem[r_xa] <= 1'b1;
        r_map_q <= map_mem[r_cur] | (r_cur == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_op == OP_CLEAR) r_clr <= r_clr + TW'(1);
            if (i_op == OP_OUT_FAIL || i_op == OP_OUT_BEST) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_func     <= i_func;
                r_x        <= i_position;
                r_size     <= i_block_size;
                r_in_range <= 32'(i_position) < POSITIONS;
                if (32'(i_position) < POSITIONS) begin
                    r_xa  <= AW'(i_position);
                    r_cur <= AW'(i_position);
                end else begin
                    r_xa  <= AW'(POSITIONS - 1);
                    r_cur <= AW'(POSITIONS - 1);
                end
            end
            OP_DEC:       r_cur  <= r_cur - AW'(1);
            OP_INC:       r_cur  <= r_cur + AW'(1);
            OP_SET_NEXT:  r_cur  <= r_xa + AW'(1);
            OP_MARK_PREV: r_prev <= r_cur;
            OP_LEAF_BEFORE: begin
                r_node <= TW'(POSITIONS) + TW'(leaf_b_pos);
                r_val  <= DW'(r_xa - r_prev);
            end
            OP_LEAF_AFTER: begin
                r_node <= TW'(POSITIONS) + TW'(r_cur);
                r_val  <= DW'(r_cur - r_xa);
            end
            OP_UP: begin
                r_node <= r_node >> 1;
                r_val  <= up_val;
            end
            OP_QINIT: begin
                r_lo   <= HW'(POSITIONS);
                r_hi   <= HW'(POSITIONS) + HW'(r_prev) + HW'(1);
                r_best <= r_x - DW'(r_prev);
            end
            OP_RD_LO: r_lo <= r_lo + HW'(1);
            OP_RD_HI: r_hi <= r_hi - HW'(1);
            OP_ACC:   r_best <= (r_tree_q > r_best) ? r_tree_q : r_best;
            OP_SHIFT: begin
                r_lo <= r_lo >> 1;
                r_hi <= r_hi >> 1;
            end
            OP_OUT_FAIL: r_fits <= 1'b0;
            OP_OUT_BEST: r_fits <= r_best >= r_size;
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_fits      = r_fits;

    always_comb begin
        o_stat.in_range  = r_in_range;
        o_stat.map_hit   = r_map_q;
        o_stat.node_gt1  = r_node > TW'(1);
        o_stat.lo_lt_hi  = r_lo < r_hi;
        o_stat.lo_odd    = r_lo[0];
        o_stat.hi_odd    = r_hi[0];
        o_stat.x_lt_size = r_x < r_size;
        o_stat.is_query  = r_func;
        o_stat.xa_last   = r_xa == AW'(POSITIONS - 1);
        o_stat.cur_last  = r_cur == AW'(POSITIONS - 1);
        o_stat.clr_last  = r_clr == TW'(2 * POSITIONS - 1);
        o_stat.out_busy  = r_out_valid && !i_out_ready;
    end

    a_dec_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_DEC) |-> (r_cur != '0))
        else $error("scan cursor stepped below zero");

    a_walk_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_SIB_RD) |-> (r_node > TW'(1)))
        else $error("tree walk read past root");

    a_best_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_OUT_BEST) |-> !(r_x < r_size))
        else $error("searched a query that cannot fit");

endmodule
`default_nettype wire

### hw/rtl/obstacle_gap_fit_query.sv
// obstacle_gap_fit_query: top level; joins the sequencer and the datapath.
// Depends on ogfq_pkg, ogfq_if, ogfq_ctrl, ogfq_dp.
//
// Keeps a set of obstacles on positions 0..POSITIONS-1 (position 0 always
// occupied) and answers whether a block of a given size fits below a query
// end x. A place item (func 0) gives no result; a query (func 1) gives one
// fits bit. Items are handled one at a time. After reset a clearing pass
// over the obstacle map and the gap max tree runs before the first item is
// accepted. A query with x < size is answered without a scan. Otherwise a
// query scans the obstacle map down from x to the nearest obstacle, then
// reads the gap max tree for the prefix max. A place scans down and up to
// the neighboring obstacles and updates the new obstacle's tree leaf and,
// if a following obstacle exists, that obstacle's leaf, walking each up the
// tree level by level. A finished result waits in an output register; the
// next item is accepted while it waits.
`default_nettype none
module obstacle_gap_fit_query #(
    parameter int POSITIONS = 1024
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ogfq_in_if.sink    i_in,
    ogfq_out_if.source o_out
);
    import ogfq_pkg::*;

    t_dp_op   op;
    t_dp_stat stat;
    logic     in_ready;

    ogfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_op       (op)
    );

    ogfq_dp #(.POSITIONS(POSITIONS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_func       (i_in.func),
        .i_position   (i_in.position),
        .i_block_size (i_in.block_size),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_fits       (o_out.fits),
        .o_stat       (stat)
    );

    assign i_in.ready = in_ready;

endmodule
`default_nettype wire

### tb/obstacle_gap_fit_query_test.sv
// obstacle_gap_fit_query_test: self-checking testbench for obstacle_gap_fit_query.
// Depends on ogfq_pkg, ogfq_if and the block's RTL; predicts each fits bit from
// its own copy of the obstacle set.
`timescale 1ns / 1ps
module obstacle_gap_fit_query_test;
    import ogfq_pkg::*;

    localparam int NPOS = 1024;

    logic i_clk;
    logic i_rst_n;

    ogfq_in_if  in_ch ();
    ogfq_out_if out_ch ();

    obstacle_gap_fit_query #(.POSITIONS(NPOS)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // 4 ns clock.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Our own copy of the obstacle set; position 0 is always occupied.
    bit          obstacle_set [NPOS];
    logic        fits_expected [$];
    int          failures = 0;
    int          stall_cycles = 0;   // long receiver hold-off, counted below
    int          ready_mode = 0;     // 0 always, 1 random, 2 mostly stalled
    int          gap_max = 4;        // sender idle cycles between bursts

    function automatic logic predict_fits(input logic [DW-1:0] x,
                                          input logic [DW-1:0] size);
        int p;
        int prev;
        int best;
        if (x < size) return 1'b0;
        p = x;
        while (p > 0 && !obstacle_set[p]) p--;
        best = x - p;
        prev = 0;
        // widest gap between consecutive obstacles at or below p
        for (int i = 1; i <= p; i++) begin
            if (obstacle_set[i]) begin
                if (i - prev > best) best = i - prev;
                prev = i;
            end
        end
        return (best >= size);
    endfunction

    // Offer one item at the falling edge, hold it until accepted, then
    // update the predictor. valid is left high; the caller lowers it for a gap.
    task automatic send_item(input logic func, input logic [DW-1:0] pos,
                             input logic [DW-1:0] size);
        in_ch.valid      = 1'b1;
        in_ch.func       = func;
        in_ch.position   = pos;
        in_ch.block_size = size;
        do @(posedge i_clk); while (!in_ch.ready);
        if (func)
            fits_expected.insert(fits_expected.size(), predict_fits(pos, size));
        else
            obstacle_set[pos] = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            in_ch.valid = 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // Send n random items in bursts; query_pct picks the mix, size_lim caps
    // most block sizes so that answers are not all zero.
    task automatic send_random(input int n, input int query_pct, input int size_lim);
        int burst;
        logic [DW-1:0] size;
        burst = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) size = DW'($urandom);
            else size = DW'($urandom_range(0, size_lim));
            send_item($urandom_range(1, 100) <= query_pct, DW'($urandom), size);
            if (--burst == 0) begin
                burst = $urandom_range(1, 8);
                idle_gap($urandom_range(0, gap_max));
            end
        end
        idle_gap(1);
    endtask

    task automatic test_directed;
        send_item(1'b1, 10'd1023, 10'd1023);  // empty line: whole span fits
        send_item(1'b1, 10'd5, 10'd6);        // x below size
        send_item(1'b1, 10'd0, 10'd0);        // zero size always fits
        send_item(1'b1, 10'd1, 10'd1);
        send_item(1'b0, 10'd0, 10'd0);        // place at zero changes nothing
        send_item(1'b0, 10'd1023, 10'd77);    // last position, size ignored
        send_item(1'b1, 10'd1023, 10'd1023);
        send_item(1'b1, 10'd1023, 10'd1022);
        send_item(1'b0, 10'd512, 10'd0);
        send_item(1'b0, 10'd512, 10'd0);      // duplicate place
        send_item(1'b1, 10'd600, 10'd512);
        send_item(1'b1, 10'd600, 10'd513);
        send_item(1'b1, 10'd1022, 10'd511);
        send_item(1'b0, 10'd1, 10'd1023);
        send_item(1'b1, 10'd1, 10'd1);
        send_item(1'b1, 10'd511, 10'd511);
        send_item(1'b1, 10'd511, 10'd510);
        send_item(1'b0, 10'd700, 10'd0);
        send_item(1'b1, 10'd1023, 10'd323);
        send_item(1'b1, 10'd1023, 10'd0);
        idle_gap(1);
    endtask

    // Receiver holds off a long time while the sender keeps offering queries.
    task automatic test_backpressure;
        stall_cycles = 3000;
        send_random(30, 100, 300);
    endtask

    task automatic test_sparse_line;
        ready_mode = 1;
        send_random(300, 70, 200);
    endtask

    task automatic test_filling_line;
        ready_mode = 0;
        gap_max = 0;
        send_random(250, 50, 40);
        ready_mode = 2;
        gap_max = 6;
        send_random(200, 60, 20);
    endtask

    task automatic test_dense_line;
        ready_mode = 1;
        send_random(250, 85, 12);
    endtask

    // Receiver: long hold-off first, otherwise a stall pattern by mode.
    always @(negedge i_clk) begin
        if (stall_cycles > 0) begin
            out_ch.ready <= 1'b0;
            stall_cycles <= stall_cycles - 1;
        end else begin
            case (ready_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: out_ch.ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Result check at each accepted item.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (fits_expected.size() == 0) begin
                $error("fits: result with no expectation, actual %0b", out_ch.fits);
                failures++;
            end else begin
                logic exp_fits;
                exp_fits = fits_expected.pop_front();
                if (out_ch.fits !== exp_fits) begin
                    $error("fits: expected %0b actual %0b", exp_fits, out_ch.fits);
                    failures++;
                end
            end
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.func       = 1'b0;
        in_ch.position   = '0;
        in_ch.block_size = '0;
        out_ch.ready     = 1'b0;
        foreach (obstacle_set[i]) obstacle_set[i] = 1'b0;
        obstacle_set[0] = 1'b1;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed;
        test_backpressure;
        test_sparse_line;
        test_filling_line;
        test_dense_line;

        while (fits_expected.size() != 0) @(posedge i_clk);
        repeat (5000) @(posedge i_clk);
        if (failures == 0 && fits_expected.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: covers the clearing pass and worst-case scans for every item.
    initial begin
        #200_000_000;
        $display("Test completed with failures");
        $finish;
    end
endmodule

### files.f
hw/rtl/ogfq_pkg.sv
hw/rtl/ogfq_if.sv
hw/rtl/ogfq_ctrl.sv
hw/rtl/ogfq_dp.sv
hw/rtl/obstacle_gap_fit_query.sv
tb/obstacle_gap_fit_query_test.sv
